// ===== rtl/smt_pkg.sv =====
// smt_pkg: shared types and constants for the sorted membership table.
// No dependencies.
package smt_pkg;
    localparam logic [1:0] OP_ADMIT  = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    localparam logic [63:0] TICK_MULT  = 64'd2654435761;
    localparam logic [63:0] TOKEN_MASK = 64'h5350AA55A55A5350;
    localparam int          CNT_W      = 7;
    localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] conn_id;
        logic [63:0] join_tick;
        logic [3:0]  leave_reason;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic        is_member;
        logic        joined_event;
        logic        left_event;
        logic [31:0] event_id;
        logic [63:0] event_tick;
        logic [3:0]  event_reason;
        logic [63:0] leave_token;
        logic [6:0]  member_count;
    } t_out_item;
endpackage

// ===== rtl/smt_front.sv =====
// smt_front: input acceptance and two-entry command queue.
// Depends on smt_pkg.
module smt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  smt_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_take,
    output smt_pkg::t_in_item o_item
);
    smt_pkg::t_in_item r_q [2];
    logic              r_wp, r_rp;
    logic [1:0]        r_cnt;
    logic              w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign o_valid = (r_cnt != 2'd0);
    assign w_pop   = o_valid && i_take;
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== rtl/smt_back.sv =====
// smt_back: sequencer that searches and shifts the ordered table in memory.
// Depends on smt_pkg.
module smt_back #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_take,
    input  smt_pkg::t_in_item   i_item,
    input  logic [6:0]          i_cap,
    output logic                o_valid,
    input  logic                i_stall,
    output smt_pkg::t_out_item  o_item
);
    localparam int AW = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;
    localparam int NW = $clog2(MAX_MEMBERS + 1);
    localparam int CW = (NW > 7) ? NW : 7;
    localparam logic [NW-1:0] MAXN = NW'(MAX_MEMBERS);

    localparam logic [2:0] S_IDLE = 3'd0, S_SRCH = 3'd1, S_WAIT = 3'd2,
                           S_INS  = 3'd3, S_DEL  = 3'd4, S_MULT = 3'd5,
                           S_OUT  = 3'd6, S_MHI  = 3'd7;

    logic [31:0] m_id  [MAX_MEMBERS];
    logic [63:0] m_tk  [MAX_MEMBERS];

    logic [2:0]  r_st;
    logic [NW-1:0] r_cnt, r_i;
    smt_pkg::t_in_item r_cmd;
    logic [31:0] r_rid;
    logic [63:0] r_rtk;
    logic        r_rv;
    logic [NW-1:0] r_p;
    logic [63:0] r_prod;
    logic [31:0] r_thi;
    smt_pkg::t_out_item r_res;
    smt_pkg::t_out_item r_out;
    logic        r_ov;

    logic [NW-1:0] w_lim;
    logic        w_full;
    logic        w_found;
    logic        w_del_end;
    logic [63:0] w_tok;
    logic [63:0] w_plo;
    logic [31:0] w_phi;
    smt_pkg::t_out_item w_nout;

    assign o_take  = (r_st == S_IDLE) && i_valid;
    assign o_valid = r_ov;
    assign o_item  = r_out;
    assign w_full  = (CW'(i_cap) <= CW'(r_cnt)) || (r_cnt >= MAXN);
    assign w_found = (r_i < r_cnt) && (r_rid == r_cmd.conn_id);
    assign w_tok   = ({r_cmd.conn_id, 32'd0} ^ r_prod) ^ smt_pkg::TOKEN_MASK;
    assign w_lim   = r_cnt;
    assign w_del_end = (r_i + NW'(1) >= w_lim);

    // tick * multiplier mod 2^64 in two 32x32 steps (multiplier fits 32 bits)
    assign w_plo = {32'd0, r_rtk[31:0]} * {32'd0, smt_pkg::TICK_MULT[31:0]};
    assign w_phi = r_thi * smt_pkg::TICK_MULT[31:0];

    // memory read (registered), one address per cycle
    logic [AW-1:0] w_ra;
    always_comb begin
        w_ra = r_i[AW-1:0];
        if (r_st == S_INS) w_ra = AW'(r_i - NW'(1));
        if (r_st == S_DEL) w_ra = AW'(r_i + NW'(1));
    end
    always_ff @(posedge i_clk) begin
        r_rid <= m_id[w_ra];
        r_rtk <= m_tk[w_ra];
    end

    logic        w_we;
    logic [AW-1:0] w_wa;
    logic [31:0] w_wid;
    logic [63:0] w_wtk;
    always_comb begin
        w_we = 1'b0; w_wa = r_i[AW-1:0]; w_wid = r_rid; w_wtk = r_rtk;
        unique case (r_st)
            S_INS: begin
                if (r_rv) w_we = 1'b1;
                if (r_i == r_p && !r_rv) begin
                    w_we = 1'b1; w_wa = r_p[AW-1:0];
                    w_wid = r_cmd.conn_id; w_wtk = r_cmd.join_tick;
                end
            end
            S_DEL: begin
                if (r_rv) w_we = 1'b1;
            end
            default: ;
        endcase
    end
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_id[w_wa] <= w_wid;
            m_tk[w_wa] <= w_wtk;
        end
    end

    // result under construction; copied to the output register in S_OUT
    always_comb begin
        w_nout = r_res;
        unique case (r_st)
            S_WAIT: begin
                w_nout = '0;
                w_nout.member_count = 7'(r_cnt);
                unique case (r_cmd.operation)
                    smt_pkg::OP_ADMIT: begin
                        if (w_full) w_nout.status = smt_pkg::ST_FULL;
                        else if (w_found) w_nout.status = smt_pkg::ST_DUP;
                    end
                    smt_pkg::OP_REMOVE: begin
                        if (!w_found) w_nout.status = smt_pkg::ST_ABSENT;
                    end
                    smt_pkg::OP_QUERY: w_nout.is_member = w_found;
                    default: ;
                endcase
            end
            S_INS: begin
                w_nout.joined_event = 1'b1;
                w_nout.event_id = r_cmd.conn_id;
                w_nout.event_tick = r_cmd.join_tick;
                w_nout.member_count = 7'(r_cnt + NW'(1));
            end
            S_MULT: begin
                w_nout.left_event = 1'b1;
                w_nout.event_id = r_cmd.conn_id;
                w_nout.event_reason = r_cmd.leave_reason;
                w_nout.leave_token = (w_tok == 64'd0) ? 64'd1 : w_tok;
                w_nout.member_count = 7'(r_cnt - NW'(1));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_cnt <= '0; r_ov <= 1'b0; r_rv <= 1'b0;
        end else begin
            if (r_st == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1; r_out <= r_res;
            end else if (r_ov && !i_stall) r_ov <= 1'b0;
            unique case (r_st)
                S_IDLE: if (i_valid) begin
                    r_cmd <= i_item; r_i <= '0; r_st <= S_SRCH;
                end
                S_SRCH: begin
                    // issue read of entry r_i; compare next cycle
                    r_st <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_i < r_cnt && r_rid < r_cmd.conn_id) begin
                        r_i <= r_i + NW'(1); r_st <= S_SRCH;
                    end else begin
                        r_p <= r_i;
                        r_res <= w_nout;
                        unique case (r_cmd.operation)
                            smt_pkg::OP_ADMIT: begin
                                if (!w_full && !w_found) begin
                                    r_i <= r_cnt; r_st <= S_INS;
                                end else r_st <= S_OUT;
                            end
                            smt_pkg::OP_REMOVE: begin
                                if (w_found) begin
                                    r_prod <= w_plo;
                                    r_thi <= r_rtk[63:32];
                                    r_st <= S_MHI;
                                end else r_st <= S_OUT;
                            end
                            default: r_st <= S_OUT;
                        endcase
                    end
                end
                S_INS: begin
                    // read i-1 issued now; write lands when r_rv
                    if (r_rv) r_i <= r_i - NW'(1);
                    if (r_i == r_p && !r_rv) begin
                        r_cnt <= r_cnt + NW'(1);
                        r_res <= w_nout;
                        r_st <= S_OUT;
                    end
                    r_rv <= !r_rv && (r_i != r_p);
                end
                S_MHI: begin
                    r_prod[63:32] <= r_prod[63:32] + w_phi;
                    r_st <= S_MULT;
                end
                S_MULT: begin
                    r_res <= w_nout;
                    r_i <= r_p;
                    r_st <= S_DEL;
                end
                S_DEL: begin
                    if (r_rv) r_i <= r_i + NW'(1);
                    if (w_del_end && !r_rv) begin
                        r_cnt <= r_cnt - NW'(1); r_st <= S_OUT;
                    end
                    r_rv <= !r_rv && !w_del_end;
                end
                S_OUT: if (!r_ov || !i_stall) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/sorted_membership_table.sv =====
// sorted_membership_table: top level, APB register and front/back wiring.
// Depends on smt_pkg, smt_front, smt_back.
//
// Input channel i_in_* carries admit, remove and query commands; output
// channel o_out_* carries one result per command. Both use valid/stall:
// a transfer happens on a clock edge with valid high and stall low.
// A two-entry queue in the front sits before the table sequencer, so
// new commands are taken while one is worked on.
// A command scans the ordered table one entry at a time up to its place,
// each entry read and then compared; an insert or delete then shifts the
// tail one entry at a time, a read and then a write per entry. Queries and
// refused commands end with the scan. One command is processed at a time;
// the sequencer takes the next one only after the last result has entered
// the output register.
// Reset (i_rst_n low, synchronous) empties the table and the queue and
// sets capacity_limit to 64; no clearing pass is needed.
// When the receiver stalls, the result register holds and the sequencer
// waits; the queue then fills and o_in_stall rises.
// capacity_limit sits at APB address 0.
module sorted_membership_table #(
    parameter int MAX_MEMBERS = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  smt_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output smt_pkg::t_out_item o_out_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [1:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [6:0] r_cap;
    logic       w_qv, w_take;
    smt_pkg::t_in_item w_qi;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? {25'd0, r_cap} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cap <= smt_pkg::CAP_RESET;
        else if (psel && penable && pwrite && paddr == 2'd0) r_cap <= pwdata[6:0];
    end

    smt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_in_valid), .o_stall(o_in_stall), .i_item(i_in_item),
        .o_valid(w_qv), .i_take(w_take), .o_item(w_qi)
    );

    smt_back #(.MAX_MEMBERS(MAX_MEMBERS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qv), .o_take(w_take), .i_item(w_qi), .i_cap(r_cap),
        .o_valid(o_out_valid), .i_stall(i_out_stall), .o_item(o_out_item)
    );
endmodule
